// ===== sv/pvx_pkg.sv =====
// ----------------------------------------------------------------------------
// pvx_pkg
// Shared types and constants for the primitive vertex expander.
// ----------------------------------------------------------------------------
`default_nettype none

package pvx_pkg;

    localparam int COORD_BITS = 24;
    localparam int INDEX_BITS = 16;
    localparam int THICK_BITS = 16;
    localparam int COLOR_BITS = 32;

    // Magnitude of a coordinate difference, its square sum and the root.
    localparam int MAG_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int LEN_BITS   = MAG_BITS;
    localparam int ROOT_STEPS = SQ_BITS / 2;
    localparam int PROD_BITS  = MAG_BITS + THICK_BITS;
    localparam int NUM_BITS   = PROD_BITS + 2;
    localparam int DEN_BITS   = LEN_BITS + 1;
    localparam int QUO_BITS   = THICK_BITS + 1;

    localparam logic [1:0] CMD_LINE  = 2'd0;
    localparam logic [1:0] CMD_RECT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [THICK_BITS-1:0] THIN_LIMIT = THICK_BITS'(256);

    localparam logic TOPO_LINE = 1'b0;
    localparam logic TOPO_TRI  = 1'b1;

    typedef struct packed {
        logic [1:0]                   command;
        logic signed [COORD_BITS-1:0] x_a;
        logic signed [COORD_BITS-1:0] y_a;
        logic signed [COORD_BITS-1:0] x_b;
        logic signed [COORD_BITS-1:0] y_b;
        logic [THICK_BITS-1:0]        thickness;
        logic [COLOR_BITS-1:0]        color;
    } cmd_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vx;
        logic signed [COORD_BITS-1:0] vy;
        logic [COLOR_BITS-1:0]        vcolor;
        logic [INDEX_BITS-1:0]        vertex_index;
        logic                         topology;
        logic                         new_batch;
        logic                         last;
    } vertex_t;

    typedef struct packed {
        logic       load;
        logic       decode;
        logic       clear;
        logic       sq_first;
        logic       sq_second;
        logic       root_step;
        logic       mul;
        logic       div_load;
        logic       div_step;
        logic       store_off;
        logic       zero_off;
        logic       emit;
        logic       commit;
        logic       sel;
        logic [1:0] k;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       thin;
        logic       zero_len;
        logic       root_done;
        logic       div_done;
        logic       out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/pvx_datapath.sv =====
// ----------------------------------------------------------------------------
// pvx_datapath
// Command register, square root and divider units, vertex output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pvx_datapath
    import pvx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_item_t cmd,
    input  wire dp_cmd_t   ctl,
    output dp_stat_t       stat,
    output logic           vert_valid,
    input  wire logic      vert_stall,
    output vertex_t        vert
);

    cmd_item_t                    item_reg;
    logic [MAG_BITS-1:0]          ax_reg, ay_reg;
    logic                         dx_neg_reg, dy_pos_reg;
    logic [SQ_BITS-1:0]           rem_reg, res_reg, bit_reg;
    logic [4:0]                   root_cnt_reg;
    logic [PROD_BITS-1:0]         prod_reg;
    logic [NUM_BITS-1:0]          num_reg;
    logic [DEN_BITS-1:0]          drem_reg;
    logic [5:0]                   div_cnt_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg;
    logic [INDEX_BITS-1:0]        next_base_reg;
    logic                         batch_topo_reg, batch_open_reg;
    logic                         vert_valid_reg;
    vertex_t                      vert_reg;

    logic signed [MAG_BITS-1:0] dx, dy;
    logic [SQ_BITS-1:0]         trial;
    logic [LEN_BITS-1:0]        len;
    logic [DEN_BITS-1:0]        den;
    logic [DEN_BITS:0]          shifted;
    logic                       ge;
    logic [MAG_BITS-1:0]        mag;
    logic [QUO_BITS-1:0]        quo;
    logic                       topo;
    logic signed [COORD_BITS-1:0] px, py;
    vertex_t                    vx_next;

    assign dx = MAG_BITS'(item_reg.x_b) - MAG_BITS'(item_reg.x_a);
    assign dy = MAG_BITS'(item_reg.y_b) - MAG_BITS'(item_reg.y_a);
    assign trial = res_reg + bit_reg;
    assign len = res_reg[LEN_BITS-1:0];
    assign den = {len, 1'b0};
    assign shifted = {drem_reg, num_reg[NUM_BITS-1]};
    assign ge = shifted >= {1'b0, den};
    assign mag = ctl.sel ? ax_reg : ay_reg;
    assign quo = num_reg[QUO_BITS-1:0];
    assign topo = (item_reg.command == CMD_RECT) || (item_reg.thickness > THIN_LIMIT);

    always_comb
    begin
        px = item_reg.x_a;
        py = item_reg.y_a;
        if (item_reg.command == CMD_RECT) begin
            case (ctl.k)
                2'd0: begin px = item_reg.x_a; py = item_reg.y_a; end
                2'd1: begin px = item_reg.x_a + item_reg.x_b; py = item_reg.y_a; end
                2'd2: begin
                    px = item_reg.x_a + item_reg.x_b;
                    py = item_reg.y_a + item_reg.y_b;
                end
                default: begin px = item_reg.x_a; py = item_reg.y_a + item_reg.y_b; end
            endcase
        end else if (!topo) begin
            px = ctl.k[0] ? item_reg.x_b : item_reg.x_a;
            py = ctl.k[0] ? item_reg.y_b : item_reg.y_a;
        end else begin
            case (ctl.k)
                2'd0: begin px = item_reg.x_a - ox_reg; py = item_reg.y_a - oy_reg; end
                2'd1: begin px = item_reg.x_a + ox_reg; py = item_reg.y_a + oy_reg; end
                2'd2: begin px = item_reg.x_b - ox_reg; py = item_reg.y_b - oy_reg; end
                default: begin px = item_reg.x_b + ox_reg; py = item_reg.y_b + oy_reg; end
            endcase
        end
        vx_next.vx = px;
        vx_next.vy = py;
        vx_next.vcolor = item_reg.color;
        vx_next.vertex_index = next_base_reg + INDEX_BITS'(ctl.k);
        vx_next.topology = topo;
        vx_next.new_batch = (ctl.k == 2'd0) && (!batch_open_reg || batch_topo_reg != topo);
        vx_next.last = topo ? (ctl.k == 2'd3) : (ctl.k == 2'd1);
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.load) item_reg <= cmd;
        if (ctl.decode) begin
            ax_reg <= dx[MAG_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
            ay_reg <= dy[MAG_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
            dx_neg_reg <= dx[MAG_BITS-1];
            dy_pos_reg <= !dy[MAG_BITS-1] && (dy != '0);
        end
        if (ctl.sq_first) rem_reg <= SQ_BITS'(ax_reg * ax_reg);
        if (ctl.sq_second) begin
            rem_reg <= rem_reg + SQ_BITS'(ay_reg * ay_reg);
            res_reg <= '0;
            bit_reg <= SQ_BITS'(1) << (SQ_BITS - 2);
            root_cnt_reg <= '0;
        end
        if (ctl.root_step) begin
            if (rem_reg >= trial) begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            root_cnt_reg <= root_cnt_reg + 5'd1;
        end
        if (ctl.mul) prod_reg <= PROD_BITS'(mag * item_reg.thickness);
        if (ctl.div_load) begin
            num_reg <= {1'b0, prod_reg, 1'b0} + NUM_BITS'(len);
            drem_reg <= '0;
            div_cnt_reg <= '0;
        end
        if (ctl.div_step) begin
            drem_reg <= ge ? DEN_BITS'(shifted - {1'b0, den}) : shifted[DEN_BITS-1:0];
            num_reg <= {num_reg[NUM_BITS-2:0], ge};
            div_cnt_reg <= div_cnt_reg + 6'd1;
        end
        if (ctl.store_off) begin
            if (ctl.sel)
                oy_reg <= dx_neg_reg ? -COORD_BITS'(quo) : COORD_BITS'(quo);
            else
                ox_reg <= dy_pos_reg ? -COORD_BITS'(quo) : COORD_BITS'(quo);
        end
        if (ctl.zero_off) begin
            ox_reg <= '0;
            oy_reg <= '0;
        end
        if (ctl.emit) vert_reg <= vx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            next_base_reg <= '0;
            batch_topo_reg <= TOPO_LINE;
            batch_open_reg <= 1'b0;
            vert_valid_reg <= 1'b0;
        end else begin
            if (ctl.clear) begin
                next_base_reg <= '0;
                batch_topo_reg <= TOPO_LINE;
                batch_open_reg <= 1'b0;
            end
            if (ctl.commit) begin
                next_base_reg <= next_base_reg + (topo ? INDEX_BITS'(4) : INDEX_BITS'(2));
                batch_topo_reg <= topo;
                batch_open_reg <= 1'b1;
            end
            if (ctl.emit)
                vert_valid_reg <= 1'b1;
            else if (!vert_stall)
                vert_valid_reg <= 1'b0;
        end
    end

    assign stat.command = item_reg.command;
    assign stat.thin = item_reg.thickness <= THIN_LIMIT;
    assign stat.zero_len = (item_reg.x_a == item_reg.x_b) && (item_reg.y_a == item_reg.y_b);
    assign stat.root_done = root_cnt_reg == 5'(ROOT_STEPS - 1);
    assign stat.div_done = div_cnt_reg == 6'(NUM_BITS - 1);
    assign stat.out_free = !vert_valid_reg || !vert_stall;

    assign vert_valid = vert_valid_reg;
    assign vert = vert_reg;

endmodule

`default_nettype wire

// ===== sv/pvx_controller.sv =====
// ----------------------------------------------------------------------------
// pvx_controller
// Sequencer that steps one command through decode, offset math and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module pvx_controller
    import pvx_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       ctl
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_SQ1    = 4'd2;
    localparam logic [3:0] ST_SQ2    = 4'd3;
    localparam logic [3:0] ST_ROOT   = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_DLOAD  = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_STORE  = 4'd8;
    localparam logic [3:0] ST_EMIT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       sel_reg, sel_next;
    logic [1:0] k_reg, k_next;
    logic       last_vertex;

    assign last_vertex = (stat.command == CMD_RECT || !stat.thin) ? (k_reg == 2'd3)
                                                                  : (k_reg == 2'd1);

    always_comb
    begin
        state_next = state_reg;
        sel_next = sel_reg;
        k_next = k_reg;
        ctl = '0;
        ctl.sel = sel_reg;
        ctl.k = k_reg;
        cmd_stall = state_reg != ST_IDLE;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    ctl.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                ctl.decode = 1'b1;
                k_next = 2'd0;
                sel_next = 1'b0;
                if (stat.command == CMD_CLEAR) begin
                    ctl.clear = 1'b1;
                    state_next = ST_IDLE;
                end else if (stat.command == CMD_RECT) begin
                    state_next = ST_EMIT;
                end else if (stat.command == CMD_LINE) begin
                    if (stat.thin) begin
                        state_next = ST_EMIT;
                    end else if (stat.zero_len) begin
                        ctl.zero_off = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_SQ1;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQ1: begin
                ctl.sq_first = 1'b1;
                state_next = ST_SQ2;
            end
            ST_SQ2: begin
                ctl.sq_second = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                ctl.root_step = 1'b1;
                if (stat.root_done) state_next = ST_MUL;
            end
            ST_MUL: begin
                ctl.mul = 1'b1;
                state_next = ST_DLOAD;
            end
            ST_DLOAD: begin
                ctl.div_load = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                ctl.div_step = 1'b1;
                if (stat.div_done) state_next = ST_STORE;
            end
            ST_STORE: begin
                ctl.store_off = 1'b1;
                sel_next = 1'b1;
                state_next = sel_reg ? ST_EMIT : ST_MUL;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    ctl.emit = 1'b1;
                    k_next = k_reg + 2'd1;
                    if (last_vertex) begin
                        ctl.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            sel_reg <= 1'b0;
            k_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            sel_reg <= sel_next;
            k_reg <= k_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/primitive_vertex_expander.sv =====
// A rectangle, a thin line or a zero-length thick line goes from the decode state straight to emission.
// A thick line of nonzero length first runs 25 square root steps and two 43-step divisions.
// The block takes one command at a time and stalls its input until the last vertex is emitted.
// Vertices leave one per cycle while the output side does not stall.
// Reset (rst_n, asynchronous, active low) clears the vertex count and the batch state.
// ----------------------------------------------------------------------------
// primitive_vertex_expander
// Expands line and rectangle draw commands into indexed list vertices; a clear command resets the index and batch.
// ----------------------------------------------------------------------------
`default_nettype none

module primitive_vertex_expander
    import pvx_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd,
    output logic           vert_valid,
    input  wire logic      vert_stall,
    output vertex_t        vert
);

    // The controller steps each command through its phases; the datapath holds
    // the command, the square root and divider units, and the output register.
    dp_cmd_t  ctl;
    dp_stat_t stat;

    pvx_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    pvx_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .ctl        (ctl),
        .stat       (stat),
        .vert_valid (vert_valid),
        .vert_stall (vert_stall),
        .vert       (vert)
    );

`ifndef SYNTHESIS
    // A command transfer always starts work, so the input side stalls next.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("input not stalled after a command transfer");

    // Every primitive has at least two vertices, so a batch opener is never last.
    a_batch_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && vert.new_batch |-> !vert.last)
        else $error("new batch flagged on a final vertex");

    // Within a command the vertices follow each other without a gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && !vert_stall && !vert.last |=> vert_valid)
        else $error("gap inside the vertices of one command");
`endif

endmodule

`default_nettype wire
